// ===== rtl/core/tpw_pkg.sv =====
// shared constants, types and state codes for the tree path weight query block
// no dependencies
package tpw_pkg;

   localparam int MAX_NODES = 1024;
   localparam int LEVELS    = 10;
   localparam int NODE_W    = $clog2(MAX_NODES);
   localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int DEPTH_W   = NODE_W;
   localparam int PREFIX_W  = 48;
   localparam int WEIGHT_W  = 32;
   localparam int PATH_W    = 44;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // table port request from the sequencer
   typedef struct packed {
      logic                node_rd;
      logic                node_wr;
      logic [NODE_W-1:0]   node_addr;
      logic [DEPTH_W-1:0]  depth_wdata;
      logic [PREFIX_W-1:0] prefix_wdata;
      logic                anc_rd;
      logic                anc_wr;
      logic [NODE_W-1:0]   anc_node;
      logic [LVL_W-1:0]    anc_lvl;
      logic [NODE_W-1:0]   anc_wdata;
   } tbl_req_type;

   // sequencer states, one-hot
   typedef enum logic [17:0] {
      S_IDLE  = 18'h00001,
      S_ARD   = 18'h00002,
      S_AWR   = 18'h00004,
      S_ALV   = 18'h00008,
      S_ALW   = 18'h00010,
      S_QRA   = 18'h00020,
      S_QRB   = 18'h00040,
      S_QDIFF = 18'h00080,
      S_QL    = 18'h00100,
      S_QLW   = 18'h00200,
      S_QEQ   = 18'h00400,
      S_QPA   = 18'h00800,
      S_QPB   = 18'h01000,
      S_QPC   = 18'h02000,
      S_QTOP  = 18'h04000,
      S_QTW   = 18'h08000,
      S_QPL   = 18'h10000,
      S_QFIN  = 18'h20000
   } state_type;

endpackage

// ===== rtl/core/tpw_addsub.sv =====
// shared 48-bit add/subtract unit for prefix weights
// depends on tpw_pkg
module tpw_addsub (
   input  logic [tpw_pkg::PREFIX_W-1:0] x,
   input  logic [tpw_pkg::PREFIX_W-1:0] y,
   input  logic                         sub,
   output logic [tpw_pkg::PREFIX_W-1:0] res
);
   import tpw_pkg::*;

   logic [PREFIX_W-1:0] y_op;

   // two's complement subtract by inverting y and carrying in
   always_comb begin
      y_op = sub ? ~y : y;
      res  = x + y_op + {{(PREFIX_W-1){1'b0}}, sub};
   end

endmodule

// ===== rtl/core/tpw_tables.sv =====
// depth, prefix and ancestor memories with registered reads
// node 0 always reads as zero; depends on tpw_pkg
module tpw_tables (
   input  logic                         clock,
   input  tpw_pkg::tbl_req_type         tbl_req,
   output logic [tpw_pkg::DEPTH_W-1:0]  depth_q,
   output logic [tpw_pkg::PREFIX_W-1:0] prefix_q,
   output logic [tpw_pkg::NODE_W-1:0]   anc_q
);
   import tpw_pkg::*;

   localparam int ANC_AW = NODE_W + LVL_W;

   logic [DEPTH_W-1:0]  depth_mem  [MAX_NODES];
   logic [PREFIX_W-1:0] prefix_mem [MAX_NODES];
   logic [NODE_W-1:0]   anc_mem    [2**ANC_AW];

   logic [DEPTH_W-1:0]  depth_rd_ff;
   logic [PREFIX_W-1:0] prefix_rd_ff;
   logic [NODE_W-1:0]   anc_rd_ff;
   logic                node_zero_ff;
   logic                anc_zero_ff;
   logic [ANC_AW-1:0]   anc_addr;

   assign anc_addr = {tbl_req.anc_node, tbl_req.anc_lvl};

   // per-node tables
   always_ff @(posedge clock) begin
      if (tbl_req.node_wr) begin
         depth_mem[tbl_req.node_addr]  <= tbl_req.depth_wdata;
         prefix_mem[tbl_req.node_addr] <= tbl_req.prefix_wdata;
      end
      if (tbl_req.node_rd) begin
         depth_rd_ff  <= depth_mem[tbl_req.node_addr];
         prefix_rd_ff <= prefix_mem[tbl_req.node_addr];
         node_zero_ff <= (tbl_req.node_addr == '0);
      end
   end

   // ancestor table, row per node, column per level
   always_ff @(posedge clock) begin
      if (tbl_req.anc_wr) begin
         anc_mem[anc_addr] <= tbl_req.anc_wdata;
      end
      if (tbl_req.anc_rd) begin
         anc_rd_ff   <= anc_mem[anc_addr];
         anc_zero_ff <= (tbl_req.anc_node == '0);
      end
   end

   // sentinel node reads as zero
   assign depth_q  = node_zero_ff ? '0 : depth_rd_ff;
   assign prefix_q = node_zero_ff ? '0 : prefix_rd_ff;
   assign anc_q    = anc_zero_ff  ? '0 : anc_rd_ff;

endmodule

// ===== rtl/core/tree_path_weight_query_top.sv =====
// tree path weight query: sequencer, table and adder instances
// depends on tpw_pkg, tpw_tables, tpw_addsub
//
// Holds a rooted weighted tree as binary-lifting tables (nodes loaded parent
// first) and answers lowest-common-ancestor path-weight queries. One request
// is worked at a time through a single read port on each table: an add reads
// the parent entry and fills the ancestor levels in turn; a query reads both
// nodes, lifts the deeper one, then lifts both in the common-ancestor pass
// and fetches the ancestor prefix, with at most one ancestor-table read a cycle.
// req_ready is low while a request is in work or a response waits.
module tree_path_weight_query_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [tpw_pkg::NODE_W-1:0]          req_node_a,
   input  logic [tpw_pkg::NODE_W-1:0]          req_node_b,
   input  logic signed [tpw_pkg::WEIGHT_W-1:0] req_weight,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tpw_pkg::NODE_W-1:0]          rsp_ancestor,
   output logic signed [tpw_pkg::PATH_W-1:0]   rsp_path_weight
);
   import tpw_pkg::*;

   localparam logic [LVL_W-1:0]   LVL_TOP = LVL_W'(LEVELS - 1);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NODES - 1);

   state_type state_ff, state_in;

   logic                op_ff;
   logic [NODE_W-1:0]   a_ff, a_in, b_ff, b_in, up_ff, up_in, top_ff, top_in, ra_ff, ra_in;
   logic [WEIGHT_W-1:0] w_ff;
   logic [LVL_W-1:0]    k_ff, k_in;
   logic [DEPTH_W-1:0]  da_ff, da_in, diff_ff, diff_in;
   logic [PREFIX_W-1:0] pa_ff, pa_in, psum_ff, psum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   anc_out_ff, anc_out_in;
   logic [PATH_W-1:0]   pw_ff, pw_in;

   tbl_req_type         tbl_req;
   logic [DEPTH_W-1:0]  depth_q;
   logic [PREFIX_W-1:0] prefix_q;
   logic [NODE_W-1:0]   anc_q;
   logic [PREFIX_W-1:0] au_x, au_y, au_res;
   logic                au_sub;
   logic                accept;

   tpw_tables u_tables (
      .clock    (clock),
      .tbl_req  (tbl_req),
      .depth_q  (depth_q),
      .prefix_q (prefix_q),
      .anc_q    (anc_q)
   );

   tpw_addsub u_addsub (
      .x   (au_x),
      .y   (au_y),
      .sub (au_sub),
      .res (au_res)
   );

   assign req_ready       = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept          = req_valid && req_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ancestor    = anc_out_ff;
   assign rsp_path_weight = pw_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      up_in        = up_ff;
      top_in       = top_ff;
      ra_in        = ra_ff;
      k_in         = k_ff;
      da_in        = da_ff;
      diff_in      = diff_ff;
      pa_in        = pa_ff;
      psum_in      = psum_ff;
      anc_out_in   = anc_out_ff;
      pw_in        = pw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      tbl_req      = '0;
      au_x         = '0;
      au_y         = '0;
      au_sub       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               a_in = req_node_a;
               b_in = req_node_b;
               if (req_op == OP_QUERY) begin
                  state_in = S_QRA;
               end else if (req_node_a != '0) begin
                  state_in = S_ARD;
               end
            end
         end
         // add: fetch parent depth and prefix
         S_ARD: begin
            tbl_req.node_rd   = 1'b1;
            tbl_req.node_addr = b_ff;
            state_in          = S_AWR;
         end
         // add: store depth, prefix and first ancestor
         S_AWR: begin
            au_x                 = prefix_q;
            au_y                 = PREFIX_W'($signed(w_ff));
            tbl_req.node_wr      = 1'b1;
            tbl_req.node_addr    = a_ff;
            tbl_req.prefix_wdata = au_res;
            if (b_ff == '0) begin
               tbl_req.depth_wdata = '0;
            end else if (depth_q == DEPTH_MAX) begin
               tbl_req.depth_wdata = depth_q;
            end else begin
               tbl_req.depth_wdata = depth_q + 1'b1;
            end
            tbl_req.anc_wr    = 1'b1;
            tbl_req.anc_node  = a_ff;
            tbl_req.anc_lvl   = '0;
            tbl_req.anc_wdata = b_ff;
            up_in             = b_ff;
            k_in              = LVL_W'(1);
            state_in          = (LEVELS > 1) ? S_ALV : S_IDLE;
         end
         // add: next level, zero above the root
         S_ALV: begin
            if (up_ff == '0) begin
               tbl_req.anc_wr    = 1'b1;
               tbl_req.anc_node  = a_ff;
               tbl_req.anc_lvl   = k_ff;
               tbl_req.anc_wdata = '0;
               k_in              = k_ff + 1'b1;
               if (k_ff == LVL_TOP) state_in = S_IDLE;
            end else begin
               tbl_req.anc_rd   = 1'b1;
               tbl_req.anc_node = up_ff;
               tbl_req.anc_lvl  = k_ff - 1'b1;
               state_in         = S_ALW;
            end
         end
         S_ALW: begin
            tbl_req.anc_wr    = 1'b1;
            tbl_req.anc_node  = a_ff;
            tbl_req.anc_lvl   = k_ff;
            tbl_req.anc_wdata = anc_q;
            up_in             = anc_q;
            k_in              = k_ff + 1'b1;
            state_in          = (k_ff == LVL_TOP) ? S_IDLE : S_ALV;
         end
         // query: read both nodes
         S_QRA: begin
            tbl_req.node_rd   = 1'b1;
            tbl_req.node_addr = a_ff;
            state_in          = S_QRB;
         end
         S_QRB: begin
            da_in             = depth_q;
            pa_in             = prefix_q;
            tbl_req.node_rd   = 1'b1;
            tbl_req.node_addr = b_ff;
            state_in          = S_QDIFF;
         end
         // query: order by depth, sum prefixes
         S_QDIFF: begin
            au_x    = pa_ff;
            au_y    = prefix_q;
            psum_in = au_res;
            if (da_ff < depth_q) begin
               a_in    = b_ff;
               b_in    = a_ff;
               diff_in = depth_q - da_ff;
            end else begin
               diff_in = da_ff - depth_q;
            end
            k_in     = LVL_TOP;
            state_in = S_QL;
         end
         // query: lift deeper node by the depth difference
         S_QL: begin
            if (diff_ff[k_ff]) begin
               tbl_req.anc_rd   = 1'b1;
               tbl_req.anc_node = a_ff;
               tbl_req.anc_lvl  = k_ff;
               state_in         = S_QLW;
            end else if (k_ff == '0) begin
               state_in = S_QEQ;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         S_QLW: begin
            a_in = anc_q;
            if (k_ff == '0) begin
               state_in = S_QEQ;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_QL;
            end
         end
         S_QEQ: begin
            if (a_ff == b_ff) begin
               top_in   = a_ff;
               state_in = S_QPL;
            end else begin
               k_in     = LVL_TOP;
               state_in = S_QPA;
            end
         end
         // query: lift both while ancestors differ
         S_QPA: begin
            tbl_req.anc_rd   = 1'b1;
            tbl_req.anc_node = a_ff;
            tbl_req.anc_lvl  = k_ff;
            state_in         = S_QPB;
         end
         S_QPB: begin
            ra_in            = anc_q;
            tbl_req.anc_rd   = 1'b1;
            tbl_req.anc_node = b_ff;
            tbl_req.anc_lvl  = k_ff;
            state_in         = S_QPC;
         end
         S_QPC: begin
            if (ra_ff != anc_q) begin
               a_in = ra_ff;
               b_in = anc_q;
            end
            if (k_ff == '0) begin
               state_in = S_QTOP;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_QPA;
            end
         end
         S_QTOP: begin
            tbl_req.anc_rd   = 1'b1;
            tbl_req.anc_node = a_ff;
            tbl_req.anc_lvl  = '0;
            state_in         = S_QTW;
         end
         S_QTW: begin
            top_in   = anc_q;
            state_in = S_QPL;
         end
         // query: fetch ancestor prefix
         S_QPL: begin
            tbl_req.node_rd   = 1'b1;
            tbl_req.node_addr = top_ff;
            state_in          = S_QFIN;
         end
         // query: subtract twice the ancestor prefix
         S_QFIN: begin
            au_x         = psum_ff;
            au_y         = {prefix_q[PREFIX_W-2:0], 1'b0};
            au_sub       = 1'b1;
            pw_in        = au_res[PATH_W-1:0];
            anc_out_in   = top_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_op;
         w_ff  <= req_weight;
      end
      a_ff       <= a_in;
      b_ff       <= b_in;
      up_ff      <= up_in;
      top_ff     <= top_in;
      ra_ff      <= ra_in;
      k_ff       <= k_in;
      da_ff      <= da_in;
      diff_ff    <= diff_in;
      pa_ff      <= pa_in;
      psum_ff    <= psum_in;
      anc_out_ff <= anc_out_in;
      pw_ff      <= pw_in;
   end

`ifndef SYNTH
   // no request taken while a response waits
   a_ready_rsp: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request accepted with response pending");

   // a response only follows a query
   a_rsp_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_QFIN) && (op_ff == OP_QUERY))
      else $error("response without query");

   // sentinel node is never written
   a_no_zero_wr: assert property (@(posedge clock) disable iff (reset)
      (tbl_req.anc_wr || tbl_req.node_wr) |->
         (tbl_req.anc_node != '0 || !tbl_req.anc_wr) &&
         (tbl_req.node_addr != '0 || !tbl_req.node_wr))
      else $error("write to node zero");
`endif

endmodule
